### rtl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 block function core.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

   typedef logic [31:0] word_type;
   typedef logic [2:0]  csr_index_type;

   localparam int WORDS = 16;

   // "expand 32-byte k"
   localparam word_type SIGMA_0 = 32'h6170_7865;
   localparam word_type SIGMA_1 = 32'h3320_646e;
   localparam word_type SIGMA_2 = 32'h7962_2d32;
   localparam word_type SIGMA_3 = 32'h6b20_6574;

   localparam int ROT_0 = 16;
   localparam int ROT_1 = 12;
   localparam int ROT_2 = 8;
   localparam int ROT_3 = 7;

   localparam csr_index_type CSR_KEY_0_1   = 3'd0;
   localparam csr_index_type CSR_KEY_2_3   = 3'd1;
   localparam csr_index_type CSR_KEY_4_5   = 3'd2;
   localparam csr_index_type CSR_KEY_6_7   = 3'd3;
   localparam csr_index_type CSR_NONCE_0_1 = 3'd4;
   localparam csr_index_type CSR_NONCE_2   = 3'd5;

   localparam logic [3:0] LAST_INDEX = 4'd15;

   function automatic word_type rotl32(input word_type v, input int n);
      rotl32 = (v << n) | (v >> (32 - n));
   endfunction

endpackage

`default_nettype wire

### rtl/chacha20_block_function_core.sv
// ----------------------------------------------------------------------------
// chacha20_block_function_core
// ChaCha20 block function: one 16-word key stream block per block counter.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req_     in         tdata[31:0] block_counter
//  rsp_     out        tdata[31:0] key_stream_word, tuser[3:0] word_index,
//                      tlast last_word
//  csr_     in         index[2:0] register, data[63:0] value
//
//  One block: a load, four steps per round on a shared four-lane
//  add/xor/rotate unit, a feed-forward add, then 16 words at one per
//  rsp_ transfer.
//  req_tready is high only while no block is in progress.
//  rsp_ stalls hold the current word; reset is synchronous and clears the
//  control state and the key/nonce registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_block_function_core #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] block_counter

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] key_stream_word
   output logic [3:0]  rsp_tuser,   // [3:0] word_index
   output logic        rsp_tlast,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
   localparam int RND_W       = (HALF_ROUNDS > 1) ? $clog2(HALF_ROUNDS) : 1;
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(HALF_ROUNDS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL, ST_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic [RND_W-1:0]   round_ff, round_in;
   logic [3:0]         emit_ff, emit_in;
   cc20_pkg::word_type held_ff;

   logic [63:0]        key_ff [4];
   logic [63:0]        nonce01_ff;
   cc20_pkg::word_type nonce2_ff;

   cc20_pkg::word_type work_ff [cc20_pkg::WORDS];
   cc20_pkg::word_type work_in [cc20_pkg::WORDS];
   cc20_pkg::word_type start_w [cc20_pkg::WORDS];

   cc20_pkg::word_type a_l [4], b_l [4], c_l [4], d_l [4];
   cc20_pkg::word_type a_n [4], b_n [4], c_n [4], d_n [4];
   cc20_pkg::word_type sum_l [4], mix_l [4], rot_l [4];

   logic req_xfer, rsp_xfer, even_step, diag;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = work_ff[0];
   assign rsp_tuser  = emit_ff;
   assign rsp_tlast  = (emit_ff == cc20_pkg::LAST_INDEX);

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;
   assign even_step = ~step_ff[0];
   assign diag      = round_ff[0];

   // initial state; counter comes straight from the port on the load cycle
   always_comb begin
      start_w[0] = cc20_pkg::SIGMA_0;
      start_w[1] = cc20_pkg::SIGMA_1;
      start_w[2] = cc20_pkg::SIGMA_2;
      start_w[3] = cc20_pkg::SIGMA_3;
      for (int k = 0; k < 4; k++) begin
         start_w[4 + 2 * k] = key_ff[k][31:0];
         start_w[5 + 2 * k] = key_ff[k][63:32];
      end
      start_w[12] = (state_ff == ST_IDLE) ? req_tdata : held_ff;
      start_w[13] = nonce01_ff[31:0];
      start_w[14] = nonce01_ff[63:32];
      start_w[15] = nonce2_ff;
   end

   // shared quarter-round step, four lanes; diagonal rounds rotate rows 1..3
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         a_l[j] = work_ff[{2'd0, 2'(j)}];
         b_l[j] = diag ? work_ff[{2'd1, 2'(j + 1)}] : work_ff[{2'd1, 2'(j)}];
         c_l[j] = diag ? work_ff[{2'd2, 2'(j + 2)}] : work_ff[{2'd2, 2'(j)}];
         d_l[j] = diag ? work_ff[{2'd3, 2'(j + 3)}] : work_ff[{2'd3, 2'(j)}];

         sum_l[j] = even_step ? (a_l[j] + b_l[j]) : (c_l[j] + d_l[j]);
         mix_l[j] = sum_l[j] ^ (even_step ? d_l[j] : b_l[j]);
         case (step_ff)
            2'd0:    rot_l[j] = cc20_pkg::rotl32(mix_l[j], cc20_pkg::ROT_0);
            2'd1:    rot_l[j] = cc20_pkg::rotl32(mix_l[j], cc20_pkg::ROT_1);
            2'd2:    rot_l[j] = cc20_pkg::rotl32(mix_l[j], cc20_pkg::ROT_2);
            default: rot_l[j] = cc20_pkg::rotl32(mix_l[j], cc20_pkg::ROT_3);
         endcase

         a_n[j] = even_step ? sum_l[j] : a_l[j];
         c_n[j] = even_step ? c_l[j]   : sum_l[j];
         d_n[j] = even_step ? rot_l[j] : d_l[j];
         b_n[j] = even_step ? b_l[j]   : rot_l[j];
      end
   end

   always_comb begin
      for (int i = 0; i < cc20_pkg::WORDS; i++) begin
         work_in[i] = work_ff[i];
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               for (int i = 0; i < cc20_pkg::WORDS; i++) begin
                  work_in[i] = start_w[i];
               end
            end
         end
         ST_ROUND: begin
            for (int k = 0; k < 4; k++) begin
               work_in[{2'd0, 2'(k)}] = a_n[k];
               work_in[{2'd1, 2'(k)}] = diag ? b_n[2'(k + 3)] : b_n[k];
               work_in[{2'd2, 2'(k)}] = diag ? c_n[2'(k + 2)] : c_n[k];
               work_in[{2'd3, 2'(k)}] = diag ? d_n[2'(k + 1)] : d_n[k];
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < cc20_pkg::WORDS; i++) begin
               work_in[i] = work_ff[i] + start_w[i];
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               for (int i = 0; i < cc20_pkg::WORDS - 1; i++) begin
                  work_in[i] = work_ff[4'(i + 1)];
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      round_in = round_ff;
      emit_in  = emit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_ROUND;
               step_in  = 2'd0;
               round_in = '0;
            end
         end
         ST_ROUND: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               if (round_ff == RND_LAST) begin
                  round_in = '0;
                  state_in = ST_FINAL;
               end else begin
                  round_in = round_ff + 1'b1;
               end
            end
         end
         ST_FINAL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               emit_in = emit_ff + 4'd1;
               if (rsp_tlast) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 2'd0;
         round_ff <= '0;
         emit_ff  <= 4'd0;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         round_ff <= round_in;
         emit_ff  <= emit_in;
         if (req_xfer) begin
            held_ff <= req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < cc20_pkg::WORDS; i++) begin
         work_ff[i] <= work_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            key_ff[k] <= '0;
         end
         nonce01_ff <= '0;
         nonce2_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cc20_pkg::CSR_KEY_0_1:   key_ff[0]  <= csr_data;
            cc20_pkg::CSR_KEY_2_3:   key_ff[1]  <= csr_data;
            cc20_pkg::CSR_KEY_4_5:   key_ff[2]  <= csr_data;
            cc20_pkg::CSR_KEY_6_7:   key_ff[3]  <= csr_data;
            cc20_pkg::CSR_NONCE_0_1: nonce01_ff <= csr_data;
            cc20_pkg::CSR_NONCE_2:   nonce2_ff  <= csr_data[31:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/cc20_checker.sv
// ----------------------------------------------------------------------------
// cc20_checker
// Port-level checks for the ChaCha20 block function core.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed under stall");

   // no new block while a block is draining
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("req_tready while rsp pending");

   // words of a block come back to back with rising index
   a_next_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 4'd1))
      else $error("word sequence broken");

   // last flag only on the final index
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == cc20_pkg::LAST_INDEX)))
      else $error("tlast mismatch");

   // block done after last transfer
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not ready after last word");

endmodule

bind chacha20_block_function_core cc20_checker u_cc20_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### tb/chacha20_block_function_core_tb.sv
// ----------------------------------------------------------------------------
// chacha20_block_function_core_tb
// Self-checking bench for the ChaCha20 block function core. Block counters go
// in on req_ in bursts, key and nonce are loaded on csr_ between phases, and
// each 16-word key stream block on rsp_ is checked against a predictor with
// its own copy of the key/nonce registers. rsp_tready stalls on its own
// pattern, including one long hold that backs the core up.
// ----------------------------------------------------------------------------
module chacha20_block_function_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROUND_PAIRS = 10;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES = 600;
   localparam int HOLD_AFTER_WORDS = 400;
   localparam int DRAIN_CYCLES = 2 + 8 * ROUND_PAIRS + 16;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 20;

   // indexes past the last register, writes there must be ignored
   localparam cc20_pkg::csr_index_type SPARE_FIRST = 3'd6;
   localparam cc20_pkg::csr_index_type SPARE_LAST  = 3'd7;

   typedef struct {
      cc20_pkg::word_type word;
      logic [3:0]         pos;
      logic               last;
   } ks_word_type;

   class keystream_scoreboard;
      logic [63:0]        regs [6];
      cc20_pkg::word_type mix [16];
      ks_word_type        pending_words [$];
      logic [3:0]         next_pos;
      int                 errors;

      function new();
         foreach (regs[k]) regs[k] = '0;
         next_pos = '0;
         errors = 0;
      endfunction

      function void set_reg(cc20_pkg::csr_index_type idx, logic [63:0] value);
         if (idx > cc20_pkg::CSR_NONCE_2) return;
         if (idx == cc20_pkg::CSR_NONCE_2) value[63:32] = '0;
         regs[idx] = value;
      endfunction

      function cc20_pkg::word_type rol(cc20_pkg::word_type v, int n);
         logic [63:0] both;
         both = {v, v} << n;
         return both[63:32];
      endfunction

      function void quarter(int a, int b, int c, int d);
         mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], cc20_pkg::ROT_0);
         mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], cc20_pkg::ROT_1);
         mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], cc20_pkg::ROT_2);
         mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], cc20_pkg::ROT_3);
      endfunction

      // one accepted counter: predict the whole 16-word block
      function void note_block(cc20_pkg::word_type counter);
         cc20_pkg::word_type init [16];
         ks_word_type item;
         init[0] = cc20_pkg::SIGMA_0;
         init[1] = cc20_pkg::SIGMA_1;
         init[2] = cc20_pkg::SIGMA_2;
         init[3] = cc20_pkg::SIGMA_3;
         for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = regs[i][31:0];
            init[5 + 2 * i] = regs[i][63:32];
         end
         init[12] = counter;
         init[13] = regs[cc20_pkg::CSR_NONCE_0_1][31:0];
         init[14] = regs[cc20_pkg::CSR_NONCE_0_1][63:32];
         init[15] = regs[cc20_pkg::CSR_NONCE_2][31:0];
         mix = init;
         for (int r = 0; r < ROUND_PAIRS; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
         end
         for (int i = 0; i < 16; i++) begin
            item.word = mix[i] + init[i];
            item.pos  = next_pos;
            item.last = (next_pos == cc20_pkg::LAST_INDEX);
            pending_words.push_back(item);
            next_pos++;
         end
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_word(cc20_pkg::word_type data, logic [3:0] pos, logic last);
         ks_word_type want;
         if (pending_words.size() == 0) begin
            report($sformatf("word %h at %0d with no block pending", data, pos));
            return;
         end
         want = pending_words.pop_front();
         if (data !== want.word)
            report($sformatf("word %0d: got %h, want %h", want.pos, data, want.word));
         if (pos !== want.pos)
            report($sformatf("index: got %0d, want %0d", pos, want.pos));
         if (last !== want.last)
            report($sformatf("last at %0d: got %b, want %b", want.pos, last, want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   keystream_scoreboard sb = new();
   cc20_pkg::word_type plan [$];
   int       cycles = 0;
   int       words_taken = 0;
   bit       hold_done = 1'b0;

   chacha20_block_function_core #(
      .DOUBLE_ROUNDS(ROUND_PAIRS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // rsp_ transfer monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         words_taken <= words_taken + 1;
      end
   end

   // receiver stall pattern, with one long hold
   initial begin : rsp_stall
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         repeat (span) begin
            @(posedge clock);
            if (!hold_done && words_taken >= HOLD_AFTER_WORDS) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_done = 1'b1;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 1) == 1);
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   function logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function cc20_pkg::word_type rand_counter();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return cc20_pkg::word_type'($urandom_range(0, 15));
         3: return '1 - cc20_pkg::word_type'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   task write_reg(cc20_pkg::csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // counters from plan, in bursts with random gaps
   task offer_plan();
      int burst;
      int gap;
      while (plan.size() > 0) begin
         burst = $urandom_range(1, 6);
         while (burst > 0 && plan.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= plan[0];
            do @(posedge clock); while (!req_tready);
            sb.note_block(plan.pop_front());
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task wait_idle(int settle);
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset value
      plan = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
               32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa};
      offer_plan();
      wait_idle(8);

      // key 00..1f, nonce 000000090000004a00000000
      write_reg(cc20_pkg::CSR_KEY_0_1,   64'h0706_0504_0302_0100);
      write_reg(cc20_pkg::CSR_KEY_2_3,   64'h0f0e_0d0c_0b0a_0908);
      write_reg(cc20_pkg::CSR_KEY_4_5,   64'h1716_1514_1312_1110);
      write_reg(cc20_pkg::CSR_KEY_6_7,   64'h1f1e_1d1c_1b1a_1918);
      write_reg(cc20_pkg::CSR_NONCE_0_1, 64'h4a00_0000_0900_0000);
      write_reg(cc20_pkg::CSR_NONCE_2,   64'h0000_0000_0000_0000);
      plan = '{32'h0000_0001, 32'h0000_0000};
      offer_plan();
      wait_idle(8);

      // all ones; upper half of the last nonce word is dropped
      for (int k = cc20_pkg::CSR_KEY_0_1; k <= cc20_pkg::CSR_NONCE_2; k++)
         write_reg(cc20_pkg::csr_index_type'(k), '1);
      for (int k = SPARE_FIRST; k <= SPARE_LAST; k++)
         write_reg(cc20_pkg::csr_index_type'(k), rand64());
      plan = '{32'hffff_ffff, 32'h0000_0000, $urandom};
      offer_plan();
      wait_idle(8);

      write_reg(cc20_pkg::CSR_KEY_0_1,   64'ha5a5_a5a5_5a5a_5a5a);
      write_reg(cc20_pkg::CSR_KEY_4_5,   64'h0000_0000_ffff_ffff);
      write_reg(cc20_pkg::CSR_NONCE_2,   64'hdead_beef_1234_5678);
      write_reg(SPARE_LAST,              '1);
      plan = '{32'h5555_5555, 32'haaaa_aaaa};
      offer_plan();
      wait_idle(8);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int k = cc20_pkg::CSR_KEY_0_1; k <= cc20_pkg::CSR_NONCE_2; k++)
            if (p == 0 || $urandom_range(0, 3) != 0)
               write_reg(cc20_pkg::csr_index_type'(k), rand64());
         if ($urandom_range(0, 3) == 0)
            write_reg(cc20_pkg::csr_index_type'($urandom_range(SPARE_FIRST, SPARE_LAST)),
                      rand64());
         repeat (ITEMS_PER_PHASE) plan.push_back(rand_counter());
         offer_plan();
         wait_idle(8);
      end

      wait_idle(DRAIN_CYCLES);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
rtl/cc20_pkg.sv
rtl/chacha20_block_function_core.sv
rtl/cc20_checker.sv
tb/chacha20_block_function_core_tb.sv
